/* src/lz_pkg.sv */
// ----------------------------------------------------------------------------
// lz_pkg
// Shared widths, item types, state codes and history chain control for the
// LZ77 token decoder.
// ----------------------------------------------------------------------------
package lz_pkg;

  localparam int HISTORY_DEPTH   = 16;
  localparam int MAX_COPY_LENGTH = 15;

  localparam int OFF_W  = 5;
  localparam int LEN_W  = 4;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int HELD_W = $clog2(HISTORY_DEPTH + 1);

  localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_COPY_LENGTH);
  localparam logic [HELD_W-1:0] HELD_FULL  = HELD_W'(HISTORY_DEPTH);

  typedef struct packed {
    logic [OFF_W-1:0]  back_offset;
    logic [LEN_W-1:0]  copy_length;
    logic [BYTE_W-1:0] literal_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_token;
    logic              bad_offset;
  } out_item_t;

  typedef struct packed {
    logic              shift;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  rd_idx;
  } hist_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_LIT,
    ST_ERR
  } dec_state_t;

endpackage

/* src/lz_cell.sv */
// ----------------------------------------------------------------------------
// lz_cell
// One history byte. On a shift it takes d_in: the byte of its newer neighbor, or the new byte at the head.
// ----------------------------------------------------------------------------
module lz_cell (
  input  logic                     clk,
  input  logic                     shift,
  input  logic [lz_pkg::BYTE_W-1:0] d_in,
  output logic [lz_pkg::BYTE_W-1:0] q
);

  logic [lz_pkg::BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_r <= d_in;
    end
  end

  assign q = byte_r;

endmodule

/* src/lz_ctrl.sv */
// ----------------------------------------------------------------------------
// lz_ctrl
// Token sequencer: checks the offset, steps through the copied run and the
// literal, drives the history chain and holds the output register.
// ----------------------------------------------------------------------------
module lz_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lz_pkg::in_item_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lz_pkg::out_item_t         out_data,
  output lz_pkg::hist_ctl_t         hist_ctl,
  input  logic [lz_pkg::BYTE_W-1:0] rd_byte
);

  lz_pkg::dec_state_t            state_r, state_nxt;
  logic [lz_pkg::OFF_W-1:0]      off_r, off_nxt;
  logic [lz_pkg::LEN_W-1:0]      cnt_r, cnt_nxt;
  logic [lz_pkg::BYTE_W-1:0]     lit_r, lit_nxt;
  logic [lz_pkg::HELD_W-1:0]     held_r, held_nxt;
  logic                          out_valid_r, out_valid_nxt;
  lz_pkg::out_item_t             out_data_r, out_data_nxt;

  logic                          accept;
  logic                          slot_free;
  logic [lz_pkg::LEN_W-1:0]      len_sat;
  logic                          bad;
  logic                          emit;
  lz_pkg::out_item_t             emit_item;
  logic                          push;
  logic [lz_pkg::OFF_W-1:0]      off_m1;

  assign accept    = in_valid && (state_r == lz_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign len_sat   = (in_data.copy_length > lz_pkg::MAX_LEN) ? lz_pkg::MAX_LEN
                                                             : in_data.copy_length;
  assign bad       = (in_data.back_offset == '0) ||
                     (32'(in_data.back_offset) > 32'(held_r));
  assign off_m1    = off_r - lz_pkg::OFF_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lz_pkg::ST_IDLE: begin
        if (accept) begin
          if (len_sat == '0) begin
            state_nxt = lz_pkg::ST_LIT;
          end else if (bad) begin
            state_nxt = lz_pkg::ST_ERR;
          end else begin
            state_nxt = lz_pkg::ST_COPY;
          end
        end
      end
      lz_pkg::ST_COPY: begin
        if (slot_free && (cnt_r == lz_pkg::LEN_W'(1))) begin
          state_nxt = lz_pkg::ST_LIT;
        end
      end
      lz_pkg::ST_LIT, lz_pkg::ST_ERR: begin
        if (slot_free) begin
          state_nxt = lz_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lz_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    push      = 1'b0;
    emit_item = '0;
    unique case (state_r)
      lz_pkg::ST_IDLE: begin
        emit = 1'b0;
      end
      lz_pkg::ST_COPY: begin
        emit               = slot_free;
        push               = slot_free;
        emit_item.out_byte = rd_byte;
      end
      lz_pkg::ST_LIT: begin
        emit                    = slot_free;
        push                    = slot_free;
        emit_item.out_byte      = lit_r;
        emit_item.last_of_token = 1'b1;
      end
      lz_pkg::ST_ERR: begin
        emit                    = slot_free;
        emit_item.last_of_token = 1'b1;
        emit_item.bad_offset    = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    off_nxt  = off_r;
    cnt_nxt  = cnt_r;
    lit_nxt  = lit_r;
    held_nxt = held_r;
    if (accept) begin
      off_nxt = in_data.back_offset;
      cnt_nxt = len_sat;
      lit_nxt = in_data.literal_byte;
    end
    if (push && (state_r == lz_pkg::ST_COPY)) begin
      cnt_nxt = cnt_r - lz_pkg::LEN_W'(1);
    end
    if (push && (held_r != lz_pkg::HELD_FULL)) begin
      held_nxt = held_r + lz_pkg::HELD_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lz_pkg::ST_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    cnt_r      <= cnt_nxt;
    lit_r      <= lit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall        = (state_r != lz_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign hist_ctl.shift  = push;
  assign hist_ctl.data   = emit_item.out_byte;
  assign hist_ctl.rd_idx = off_m1[lz_pkg::IDX_W-1:0];

endmodule

/* src/lz77_token_decoder_unit.sv */
// ----------------------------------------------------------------------------
// lz77_token_decoder_unit
// LZ77 token decoder. Each input item is one token (back offset, copy length,
// literal byte). The block emits the copied history bytes, oldest first, and
// then the literal, one result item per cycle. The literal carries
// last_of_token. A copy may overlap the bytes it produces.
// A token with nonzero copy length and a zero offset, or an offset beyond the
// bytes held, yields one result with bad_offset set and out_byte zero and
// leaves history unchanged. A token is registered into the sequencer state,
// and its first result is then registered into the output register. Each
// emitted copy or literal byte is shifted into the history cell chain.
// The input is stalled while a token is being expanded; the next token is
// taken as soon as its predecessor's last result sits in the output register.
// A stalled output holds its item and pauses the expansion.
// Reset empties the history count and the output register; history bytes
// themselves are not cleared.
// ----------------------------------------------------------------------------
module lz77_token_decoder_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lz_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lz_pkg::out_item_t out_data
);

  lz_pkg::hist_ctl_t         hist_ctl;
  logic [lz_pkg::BYTE_W-1:0] cell_q [lz_pkg::HISTORY_DEPTH];
  logic [lz_pkg::BYTE_W-1:0] rd_byte;

  lz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .hist_ctl  (hist_ctl),
    .rd_byte   (rd_byte)
  );

  for (genvar i = 0; i < lz_pkg::HISTORY_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      lz_cell u_cell (
        .clk   (clk),
        .shift (hist_ctl.shift),
        .d_in  (hist_ctl.data),
        .q     (cell_q[i])
      );
    end else begin : g_body
      lz_cell u_cell (
        .clk   (clk),
        .shift (hist_ctl.shift),
        .d_in  (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  assign rd_byte = cell_q[hist_ctl.rd_idx];

endmodule

/* src/lz_checker.sv */
// ----------------------------------------------------------------------------
// lz_checker
// Port-level checks for the LZ77 token decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lz_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input lz_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_offset |-> out_data.last_of_token && (out_data.out_byte == '0))
    else $error("error item is not a zero last item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while a token is expanded");

  a_idle_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid || out_data.last_of_token)
    else $error("input open while a token is unfinished");

endmodule

bind lz77_token_decoder_unit lz_checker u_lz_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
